// ===== rtl/toeq_pkg.sv =====
// Types and codes shared by the time-ordered event queue.
// No dependencies.
package toeq_pkg;

    localparam int TIME_W = 32;
    localparam int ID_W   = 16;
    localparam int OCC_W  = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic shift_in;
        logic at_front;
        logic shift_out;
    } cell_ctrl_t;

endpackage

// ===== rtl/toeq_cell.sv =====
// One slot of the sorted queue: holds a time and an id, trades with neighbours.
// Depends on toeq_pkg.
module toeq_cell (
    input  logic                            clk,
    input  toeq_pkg::cell_ctrl_t            ctrl,
    input  logic                            occupied,
    input  logic [toeq_pkg::TIME_W-1:0]     in_time,
    input  logic [toeq_pkg::ID_W-1:0]       in_id,
    input  logic [toeq_pkg::TIME_W-1:0]     left_time,
    input  logic [toeq_pkg::ID_W-1:0]       left_id,
    input  logic                            left_keep,
    input  logic [toeq_pkg::TIME_W-1:0]     right_time,
    input  logic [toeq_pkg::ID_W-1:0]       right_id,
    output logic [toeq_pkg::TIME_W-1:0]     slot_time,
    output logic [toeq_pkg::ID_W-1:0]       slot_id,
    output logic                            keep
);
    import toeq_pkg::*;

    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;

    // hold only while every slot towards the head also holds
    assign keep = left_keep && occupied && !ctrl.at_front && (time_reg <= in_time);

    always_comb
    begin
        time_next = time_reg;
        id_next   = id_reg;
        if (ctrl.shift_in && !keep)
        begin
            if (left_keep)
            begin
                time_next = in_time;
                id_next   = in_id;
            end
            else
            begin
                time_next = left_time;
                id_next   = left_id;
            end
        end
        else if (ctrl.shift_out)
        begin
            time_next = right_time;
            id_next   = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign slot_time = time_reg;
    assign slot_id   = id_reg;

endmodule

// ===== rtl/time_ordered_event_queue_top.sv =====
// Time-ordered event queue: a row of sorting cells with count and result register.
// Depends on toeq_pkg and toeq_cell.
//
// Usage:
//   Each input item is one operation: ordered insert (after every entry with
//   equal or smaller time), push to front, or pop of the head entry; code 3 is a no-op.
//   Every accepted item gives exactly one result item carrying a status
//   (ok, empty on pop, full on insert or push), the popped time and id
//   (zero otherwise) and the number of entries held afterwards.
//   The result is registered and reaches the output channel in the cycle
//   after acceptance. One item is accepted per cycle unless the output
//   stalls: every cell compares its own time with the new key and shifts
//   in the same cycle; the row of cells sets the rate, independent of QUEUE_DEPTH.
//   s_axis_tready is high while the result register is empty or being
//   taken; a stalled receiver holds the result and stops intake after it.
//   Reset empties the queue at once; slot contents are left as they are
//   and never read before being written.
module time_ordered_event_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] event_time, [47:32] event_id
    input  logic [toeq_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // [1:0] operation
    input  logic [toeq_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] out_time, [47:32] out_id, [52:48] occupancy, [55:53] zero
    output logic [toeq_pkg::M_DATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [toeq_pkg::ST_W-1:0]         m_axis_tuser
);
    import toeq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic              accept;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] in_time;
    logic [ID_W-1:0]   in_id;
    logic              is_full;
    logic              is_empty;
    cell_ctrl_t        ctrl;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [ST_W-1:0]   status_reg;
    logic [ST_W-1:0]   status_next;
    logic [TIME_W-1:0] rtime_reg;
    logic [TIME_W-1:0] rtime_next;
    logic [ID_W-1:0]   rid_reg;
    logic [ID_W-1:0]   rid_next;

    logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
    logic [ID_W-1:0]   cell_id   [QUEUE_DEPTH];
    logic              cell_keep [QUEUE_DEPTH];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign in_time       = s_axis_tdata[TIME_W-1:0];
    assign in_id         = s_axis_tdata[TIME_W+ID_W-1:TIME_W];
    assign is_full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty      = (count_reg == '0);

    always_comb
    begin
        ctrl.shift_in  = accept && (op == OP_INSERT || op == OP_FRONT) && !is_full;
        ctrl.at_front  = (op == OP_FRONT);
        ctrl.shift_out = accept && (op == OP_POP) && !is_empty;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [TIME_W-1:0] l_time;
            logic [ID_W-1:0]   l_id;
            logic              l_keep;
            logic [TIME_W-1:0] r_time;
            logic [ID_W-1:0]   r_id;

            if (gi == 0)
            begin : g_head
                assign l_time = in_time;
                assign l_id   = in_id;
                assign l_keep = 1'b1;
            end
            else
            begin : g_mid
                assign l_time = cell_time[gi-1];
                assign l_id   = cell_id[gi-1];
                assign l_keep = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_time = '0;
                assign r_id   = '0;
            end
            else
            begin : g_inner
                assign r_time = cell_time[gi+1];
                assign r_id   = cell_id[gi+1];
            end

            toeq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CNT_W'(gi)),
                .in_time    (in_time),
                .in_id      (in_id),
                .left_time  (l_time),
                .left_id    (l_id),
                .left_keep  (l_keep),
                .right_time (r_time),
                .right_id   (r_id),
                .slot_time  (cell_time[gi]),
                .slot_id    (cell_id[gi]),
                .keep       (cell_keep[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        status_next  = status_reg;
        rtime_next   = rtime_reg;
        rid_next     = rid_reg;
        if (ctrl.shift_in)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.shift_out)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept)
        begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            rtime_next   = '0;
            rid_next     = '0;
            unique case (op)
                OP_INSERT, OP_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rtime_next = cell_time[0];
                        rid_next   = cell_id[0];
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rtime_reg  <= rtime_next;
        rid_reg    <= rid_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {3'b000, OCC_W'(count_reg), rid_reg, rtime_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_POP && !is_empty) |=>
            (m_axis_tdata[TIME_W-1:0] == $past(cell_time[0])
             && count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not return head entry");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_INSERT || op == OP_FRONT) && is_full) |=>
            (m_axis_tuser == ST_FULL && count_reg == $past(count_reg)))
        else $error("insert into full queue not dropped");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_POP && is_empty) |=>
            (m_axis_tuser == ST_EMPTY && count_reg == '0))
        else $error("pop of empty queue mishandled");

endmodule
